// File: sv/frustum_box_cull_assert.svh
// frustum_box_cull_assert.svh: assertion macros for the frustum box cull block
// no dependencies; used by frustum_box_cull.sv
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fbc_pkg.sv
// fbc_pkg: widths, item kinds and plane types for the frustum box cull block
// no dependencies; used by fbc_matrix and frustum_box_cull
package fbc_pkg;

  localparam int MAX_PLANES   = 6;
  localparam int ENT_W        = 24;             // Q8.16 matrix entry
  localparam int COORD_W      = 32;             // Q16.16 coordinate
  localparam int HALF_W       = 16;
  localparam int MPROD_W      = 2 * ENT_W;      // one P*V product
  localparam int M_W          = MPROD_W + 2;    // sum of four products
  localparam int PL_W         = M_W + 1;        // plane component
  localparam int LO_PROD_W    = PL_W + HALF_W + 1;
  localparam int HI_PROD_W    = PL_W + HALF_W;
  localparam int PROD_W       = PL_W + COORD_W + 1;
  localparam int SUM_W        = PROD_W + 2;
  localparam int MAT_ENTRIES  = 16;
  localparam int MAT_IDX_W    = 4;

  typedef enum logic [1:0] {
    KIND_LOAD_PROJ = 2'd0,
    KIND_LOAD_VIEW = 2'd1,
    KIND_BOX       = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  typedef logic signed [PL_W-1:0] comp_t;
  typedef comp_t [3:0] plane_t;

  // matrix engine status toward the box pipeline
  typedef struct packed {
    logic busy;   // recomputing the combined matrix
    logic dirty;  // a store changed, planes are stale
  } mat_status_t;

endpackage

// File: sv/fbc_matrix.sv
// fbc_matrix: projection and view stores, serial P*V product and plane registers
// depends on fbc_pkg
module fbc_matrix import fbc_pkg::*; #(
  parameter int PLANE_COUNT = MAX_PLANES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load_en,
  input  logic                    load_view,
  input  logic [MAT_IDX_W-1:0]    load_idx,
  input  logic signed [ENT_W-1:0] load_val,
  input  logic                    hold,
  output mat_status_t             status,
  output plane_t                  planes [PLANE_COUNT]
);

  localparam int ISSUE_LEN = MAT_ENTRIES * 4;
  localparam int CNT_W     = $clog2(ISSUE_LEN) + 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ISSUE_LEN + 1);

  logic signed [ENT_W-1:0]   proj_r [MAT_ENTRIES];
  logic signed [ENT_W-1:0]   view_r [MAT_ENTRIES];
  logic signed [M_W-1:0]     m_r    [MAT_ENTRIES];
  plane_t                    plane_r [PLANE_COUNT];
  plane_t                    plane_nxt [PLANE_COUNT];
  logic [CNT_W-1:0]          cnt_r;
  logic                      run_r;
  logic                      dirty_r;
  logic signed [MPROD_W-1:0] prod_r;
  logic                      pv_r, pfirst_r, plast_r;
  logic [MAT_IDX_W-1:0]      pidx_r;
  logic signed [M_W-1:0]     acc_r;
  logic signed [M_W-1:0]     acc_nxt;
  logic                      start, issue;
  logic [1:0]                col, row, kk;

  assign start = dirty_r & ~run_r & ~hold & ~load_en;
  assign issue = run_r & ~cnt_r[CNT_W-1];
  assign col   = cnt_r[5:4];
  assign row   = cnt_r[3:2];
  assign kk    = cnt_r[1:0];

  // running sum of the four products of one combined entry
  assign acc_nxt = (pfirst_r ? '0 : acc_r) + M_W'(prod_r);

  // plane components from the combined matrix
  always_comb begin
    for (int n = 0; n < PLANE_COUNT; n++) begin
      for (int c = 0; c < 4; c++) begin
        if (n % 2 == 0) begin
          plane_nxt[n][c] = PL_W'(m_r[c*4+3]) + PL_W'(m_r[c*4+n/2]);
        end else begin
          plane_nxt[n][c] = PL_W'(m_r[c*4+3]) - PL_W'(m_r[c*4+n/2]);
        end
      end
    end
  end

  // stores, sequencer and plane registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_ENTRIES; i++) begin
        proj_r[i] <= '0;
        view_r[i] <= '0;
        m_r[i]    <= '0;
      end
      for (int n = 0; n < PLANE_COUNT; n++) begin
        plane_r[n] <= '0;
      end
      cnt_r   <= '0;
      run_r   <= 1'b0;
      dirty_r <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      if (load_en) begin
        dirty_r <= 1'b1;
        if (load_view) begin
          view_r[load_idx] <= load_val;
        end else begin
          proj_r[load_idx] <= load_val;
        end
      end
      if (start) begin
        run_r   <= 1'b1;
        dirty_r <= 1'b0;
        cnt_r   <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          run_r   <= 1'b0;
          plane_r <= plane_nxt;
        end
      end
      pv_r <= issue;
      if (pv_r) begin
        acc_r <= acc_nxt;
        if (plast_r) begin
          m_r[pidx_r] <= acc_nxt;
        end
      end
    end
  end

  // one product per cycle: P[row r, col k] * V[row k, col c]
  always_ff @(posedge clk) begin
    prod_r   <= proj_r[{kk, row}] * view_r[{col, kk}];
    pfirst_r <= (kk == 2'd0);
    plast_r  <= (kk == 2'd3);
    pidx_r   <= {col, row};
  end

  assign status.busy  = run_r;
  assign status.dirty = dirty_r;
  assign planes       = plane_r;

endmodule

// File: sv/frustum_box_cull.sv
// frustum_box_cull: axis-aligned box test against six frustum planes
// depends on fbc_pkg, fbc_matrix and frustum_box_cull_assert.svh
//
// Usage: one input channel (in_valid / in_stall) carries load items and box
// items; one result channel (out_valid / out_stall) carries the visible flag.
// A load item writes one entry of the projection or view store (index
// col*4+row) and gives no result. After the last of a run of loads the block
// rebuilds the combined matrix with one 24x24 multiplier, one product a cycle;
// further items are held off during the rebuild. Box items wait while that
// rebuild is pending or running.
// With fixed matrices a box item enters every cycle while the result channel
// does not stall; its flag passes through the five register stages (sort,
// split multiply, product merge, dot sum, sign check).
// Reset clears both stores, the combined matrix and the planes to zero, so a
// box tested before any load is culled.
// While a result waits on out_stall the box pipeline holds; no item is lost.
`include "frustum_box_cull_assert.svh"

module frustum_box_cull import fbc_pkg::*; #(
  parameter int PLANE_COUNT = MAX_PLANES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_kind,
  input  logic [1:0]                in_entry_col,
  input  logic [1:0]                in_entry_row,
  input  logic signed [ENT_W-1:0]   in_entry_value,
  input  logic signed [COORD_W-1:0] in_min_x,
  input  logic signed [COORD_W-1:0] in_min_y,
  input  logic signed [COORD_W-1:0] in_min_z,
  input  logic signed [COORD_W-1:0] in_max_x,
  input  logic signed [COORD_W-1:0] in_max_y,
  input  logic signed [COORD_W-1:0] in_max_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_visible
);

  mat_status_t status;
  plane_t      planes [PLANE_COUNT];
  logic        en, is_box, is_load, box_acc, load_acc, hold;

  logic signed [COORD_W-1:0]   in_lo [3];
  logic signed [COORD_W-1:0]   in_hi [3];
  logic signed [COORD_W-1:0]   lo0_r [3];
  logic signed [COORD_W-1:0]   hi0_r [3];
  logic signed [COORD_W-1:0]   q_sel [PLANE_COUNT][3];
  logic signed [LO_PROD_W-1:0] pl1_r [PLANE_COUNT][3];
  logic signed [HI_PROD_W-1:0] ph1_r [PLANE_COUNT][3];
  logic signed [PL_W-1:0]      pw1_r [PLANE_COUNT];
  logic signed [PROD_W-1:0]    pr2_r [PLANE_COUNT][3];
  logic signed [PL_W-1:0]      pw2_r [PLANE_COUNT];
  logic signed [SUM_W-1:0]     sum3_r [PLANE_COUNT];
  logic [PLANE_COUNT-1:0]      hit;
  logic v0_r, v1_r, v2_r, v3_r, out_valid_r, out_visible_r;

  // handshake
  assign en       = ~out_valid_r | ~out_stall;
  assign is_box   = (kind_t'(in_kind) == KIND_BOX);
  assign is_load  = (kind_t'(in_kind) == KIND_LOAD_PROJ) |
                    (kind_t'(in_kind) == KIND_LOAD_VIEW);
  assign in_stall = status.busy | (is_box & (~en | status.dirty));
  assign box_acc  = in_valid & ~in_stall & is_box;
  assign load_acc = in_valid & ~in_stall & is_load;
  assign hold     = v0_r | (in_valid & is_load);

  fbc_matrix #(.PLANE_COUNT(PLANE_COUNT)) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (load_acc),
    .load_view (kind_t'(in_kind) == KIND_LOAD_VIEW),
    .load_idx  ({in_entry_col, in_entry_row}),
    .load_val  (in_entry_value),
    .hold      (hold),
    .status    (status),
    .planes    (planes)
  );

  assign in_lo = '{in_min_x, in_min_y, in_min_z};
  assign in_hi = '{in_max_x, in_max_y, in_max_z};

  // corner per plane: larger coordinate for a non-negative normal component
  always_comb begin
    for (int n = 0; n < PLANE_COUNT; n++) begin
      for (int c = 0; c < 3; c++) begin
        q_sel[n][c] = planes[n][c][PL_W-1] ? lo0_r[c] : hi0_r[c];
      end
    end
  end

  // dot product sign per plane
  always_comb begin
    for (int n = 0; n < PLANE_COUNT; n++) begin
      hit[n] = (sum3_r[n] > 0);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= box_acc;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: order each coordinate pair
      for (int c = 0; c < 3; c++) begin
        lo0_r[c] <= (in_lo[c] < in_hi[c]) ? in_lo[c] : in_hi[c];
        hi0_r[c] <= (in_lo[c] < in_hi[c]) ? in_hi[c] : in_lo[c];
      end
      for (int n = 0; n < PLANE_COUNT; n++) begin
        // stage 1: coordinate split in halves, two narrow products
        for (int c = 0; c < 3; c++) begin
          pl1_r[n][c] <= $signed(planes[n][c]) *
                         $signed({1'b0, q_sel[n][c][HALF_W-1:0]});
          ph1_r[n][c] <= $signed(planes[n][c]) *
                         $signed(q_sel[n][c][COORD_W-1:HALF_W]);
        end
        pw1_r[n] <= $signed(planes[n][3]);
        // stage 2: merge halves
        for (int c = 0; c < 3; c++) begin
          pr2_r[n][c] <= (PROD_W'(ph1_r[n][c]) <<< HALF_W) + PROD_W'(pl1_r[n][c]);
        end
        pw2_r[n] <= pw1_r[n];
        // stage 3: dot product plus w term
        sum3_r[n] <= SUM_W'(pr2_r[n][0]) + SUM_W'(pr2_r[n][1]) +
                     SUM_W'(pr2_r[n][2]) + (SUM_W'(pw2_r[n]) <<< HALF_W);
      end
      // stage 4: visible when every plane sees a corner
      out_visible_r <= &hit;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  // checks
  `FBC_ASSERT_NOW(a_box_fresh_planes, box_acc, !status.dirty && !status.busy,
                  "box item taken while planes are stale")
  `FBC_ASSERT_NOW(a_rebuild_empty_s0, status.busy, !v0_r,
                  "plane rebuild running with a box waiting to read planes")
  `FBC_ASSERT_NEXT(a_pipe_advance, v3_r && en, out_valid,
                   "box item lost between last stage and output")

endmodule

// File: verif/fbc_checker.sv
// fbc_checker: watches both channels of frustum_box_cull, predicts the visible flag
// depends on fbc_pkg; instantiated by frustum_box_cull_tb beside the block
`timescale 1ns / 100ps

module fbc_checker import fbc_pkg::*; #(
  parameter int PLANE_COUNT = MAX_PLANES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                in_kind,
  input  logic [1:0]                in_entry_col,
  input  logic [1:0]                in_entry_row,
  input  logic signed [ENT_W-1:0]   in_entry_value,
  input  logic signed [COORD_W-1:0] in_min_x,
  input  logic signed [COORD_W-1:0] in_min_y,
  input  logic signed [COORD_W-1:0] in_min_z,
  input  logic signed [COORD_W-1:0] in_max_x,
  input  logic signed [COORD_W-1:0] in_max_y,
  input  logic signed [COORD_W-1:0] in_max_z,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_visible,
  output int                        fail_count,
  output int                        flags_waiting,
  output int                        visible_count,
  output int                        culled_count
);

  logic signed [ENT_W-1:0] proj_store [MAT_ENTRIES];
  logic signed [ENT_W-1:0] view_store [MAT_ENTRIES];
  bit visible_fifo [$];

  assign flags_waiting = visible_fifo.size();

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // exact box-against-planes test on the current stores
  function automatic bit box_visible(input logic signed [COORD_W-1:0] lo [3],
                                     input logic signed [COORD_W-1:0] hi [3]);
    longint comb [4][4];
    longint pl [4];
    logic signed [127:0] acc, a, b;
    bit hit;
    int ax;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        comb[c][r] = 0;
        for (int k = 0; k < 4; k++)
          comb[c][r] += longint'(proj_store[k*4+r]) * longint'(view_store[c*4+k]);
      end
    end
    for (int n = 0; n < ((PLANE_COUNT > MAX_PLANES) ? MAX_PLANES : PLANE_COUNT); n++) begin
      ax = n / 2;
      for (int c = 0; c < 4; c++)
        pl[c] = (n % 2) ? comb[c][3] - comb[c][ax] : comb[c][3] + comb[c][ax];
      hit = 0;
      for (int corner = 0; corner < 8; corner++) begin
        acc = pl[3];
        acc = acc <<< HALF_W;
        for (int c = 0; c < 3; c++) begin
          a = pl[c];
          b = ((corner >> c) & 1) ? hi[c] : lo[c];
          acc += a * b;
        end
        if (acc > 0) hit = 1;
      end
      if (!hit) return 0;
    end
    return 1;
  endfunction

  // predict on each accepted input item
  always @(posedge clk) begin
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    if (!rst_n) begin
      for (int i = 0; i < MAT_ENTRIES; i++) begin
        proj_store[i] = '0;
        view_store[i] = '0;
      end
      visible_fifo.delete();
    end else if (in_valid && !in_stall) begin
      case (kind_t'(in_kind))
        KIND_LOAD_PROJ: proj_store[{in_entry_col, in_entry_row}] = in_entry_value;
        KIND_LOAD_VIEW: view_store[{in_entry_col, in_entry_row}] = in_entry_value;
        KIND_BOX: begin
          lo[0] = in_min_x; lo[1] = in_min_y; lo[2] = in_min_z;
          hi[0] = in_max_x; hi[1] = in_max_y; hi[2] = in_max_z;
          visible_fifo.push_back(box_visible(lo, hi));
        end
        default: ;
      endcase
    end
  end

  // compare each accepted result item with the oldest prediction
  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      fail_count    <= 0;
      visible_count <= 0;
      culled_count  <= 0;
    end else if (out_valid && !out_stall) begin
      if (visible_fifo.size() == 0) begin
        report("result item with no box item waiting");
      end else begin
        want = visible_fifo.pop_front();
        if (out_visible !== want)
          report($sformatf("visible got %b want %b", out_visible, want));
        if (want) visible_count <= visible_count + 1;
        else culled_count <= culled_count + 1;
      end
    end
  end

endmodule

// File: verif/frustum_box_cull_tb.sv
// frustum_box_cull_tb: stimulus, idling and verdict for frustum_box_cull
// depends on fbc_pkg, frustum_box_cull and fbc_checker
`timescale 1ns / 100ps

module frustum_box_cull_tb;
  import fbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1120;
  localparam int ONE            = 65536;

  logic                      clk = 0;
  logic                      rst_n = 0;
  logic                      in_valid = 0;
  logic                      in_stall;
  logic [1:0]                in_kind = KIND_NONE;
  logic [1:0]                in_entry_col = '0;
  logic [1:0]                in_entry_row = '0;
  logic signed [ENT_W-1:0]   in_entry_value = '0;
  logic signed [COORD_W-1:0] in_min_x = '0, in_min_y = '0, in_min_z = '0;
  logic signed [COORD_W-1:0] in_max_x = '0, in_max_y = '0, in_max_z = '0;
  logic                      out_valid;
  logic                      out_stall = 0;
  logic                      out_visible;
  int fail_count, flags_waiting, visible_count, culled_count;
  int idle_cycles = 0;
  int items_sent = 0;

  always #1 clk = ~clk;

  frustum_box_cull dut (.*);

  fbc_checker u_checker (.*);

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item and hold it until accepted
  task automatic put_item(input kind_t kind, input logic [1:0] col, input logic [1:0] row,
                          input logic signed [ENT_W-1:0] value,
                          input logic signed [COORD_W-1:0] lx, ly, lz, hx, hy, hz,
                          input bit idle_ok);
    int gap;
    gap = idle_ok ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1;
    in_kind        <= kind;
    in_entry_col   <= col;
    in_entry_row   <= row;
    in_entry_value <= value;
    in_min_x <= lx; in_min_y <= ly; in_min_z <= lz;
    in_max_x <= hx; in_max_y <= hy; in_max_z <= hz;
    @(posedge clk iff !in_stall);
    items_sent++;
  endtask

  task automatic load_entry(input kind_t kind, input int col, input int row,
                            input int value, input bit idle_ok);
    put_item(kind, col[1:0], row[1:0], value[ENT_W-1:0], $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, idle_ok);
  endtask

  task automatic test_box(input int lx, ly, lz, hx, hy, hz, input bit idle_ok);
    put_item(KIND_BOX, 2'($urandom), 2'($urandom), ENT_W'($urandom),
             lx, ly, lz, hx, hy, hz, idle_ok);
  endtask

  // projection and view near identity with small off-diagonal terms, or fully random matrices
  task automatic load_matrices(input bit wild);
    int v;
    for (int m = 0; m < 2; m++) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          if (wild) v = $urandom;
          else if (c == r) v = ONE + $signed($urandom_range(0, 2 * ONE)) - ONE / 2;
          else v = $signed($urandom_range(0, ONE / 2)) - ONE / 4;
          load_entry(m ? KIND_LOAD_VIEW : KIND_LOAD_PROJ, c, r, v, 1);
        end
      end
    end
  endtask

  function automatic int coord(input bit wide);
    return wide ? $urandom : $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
  endfunction

  task automatic random_box(input bit idle_ok);
    int lx, ly, lz, sx, sy, sz;
    bit wide;
    wide = ($urandom_range(9) == 0);
    lx = coord(wide); ly = coord(wide); lz = coord(wide);
    sx = wide ? $urandom : $urandom_range(0, 2 * ONE);
    sy = wide ? $urandom : $urandom_range(0, 2 * ONE);
    sz = wide ? $urandom : $urandom_range(0, 2 * ONE);
    if ($urandom_range(19) == 0) test_box(lx, ly, lz, lx - sx, ly - sy, lz - sz, idle_ok);
    else test_box(lx, ly, lz, lx + sx, ly + sy, lz + sz, idle_ok);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (flags_waiting != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // reset, directed items, then random traffic
  initial begin
    bit calm;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // zero matrices give zero planes, so the box is culled
    test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0);
    // identity projection and view
    for (int c = 0; c < 4; c++) begin
      load_entry(KIND_LOAD_PROJ, c, c, ONE, 0);
      load_entry(KIND_LOAD_VIEW, c, c, ONE, 0);
    end
    test_box(-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, ONE / 2, ONE / 2, 0);
    test_box(3 * ONE, 3 * ONE, 3 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 0);
    test_box(ONE, 0, 0, 2 * ONE, ONE / 4, ONE / 4, 0);
    test_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    test_box(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
    test_box(32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff, 0, 0, 0);
    // ignored kind
    put_item(KIND_NONE, 2'd3, 2'd3, 24'sh7fffff, 0, 0, 0, 0, 0, 0, 0);
    test_box(ONE / 2, ONE / 2, ONE / 2, -ONE / 2, -ONE / 2, -ONE / 2, 0);
    // extreme entries
    load_entry(KIND_LOAD_PROJ, 3, 3, 24'sh7fffff, 0);
    load_entry(KIND_LOAD_VIEW, 0, 3, 24'sh800000, 0);
    test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0);
    test_box(32'sh8000_0000, -ONE, 0, -ONE, ONE, 32'sh7fff_ffff, 0);

    // random part: matrix sets, then bursts of mostly boxes with stray loads and ignored kinds
    while (items_sent < RANDOM_ITEMS) begin
      load_matrices($urandom_range(7) == 0);
      calm = ($urandom_range(3) == 0);
      repeat ($urandom_range(30, 120)) begin
        if ($urandom_range(49) == 0)
          put_item(KIND_NONE, 2'($urandom), 2'($urandom), ENT_W'($urandom),
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, !calm);
        else if ($urandom_range(29) == 0)
          load_entry(kind_t'($urandom_range(1)), $urandom_range(3), $urandom_range(3),
                     $urandom, !calm);
        else random_box(!calm);
      end
      if ($urandom_range(3) == 0) wait_drained();
    end
    wait_drained();

    $display("run covered %0d items: %0d visible and %0d culled boxes",
             items_sent, visible_count, culled_count);
    $display("with identity, near-identity and fully random matrices, ignored kinds");
    if (fail_count == 0 && flags_waiting == 0) begin
      $display("** frustum_box_cull: PASSED **");
    end else begin
      $display("** frustum_box_cull: FAILED **");
    end
    $finish;
  end

  // result side: random stalls, with one long hold while the sender keeps offering
  initial begin
    int gap;
    wait (rst_n);
    repeat (1500) @(posedge clk);
    out_stall <= 1;
    repeat (400) @(posedge clk);
    forever begin
      gap = ($urandom_range(3) == 0) ? 0 : gap_len();
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("** frustum_box_cull: FAILED **");
        $finish;
      end
    end
  end

endmodule

// File: files.f
+incdir+sv
sv/fbc_pkg.sv
sv/fbc_matrix.sv
sv/frustum_box_cull.sv
verif/fbc_checker.sv
verif/frustum_box_cull_tb.sv
